[hdl/plp_pkg.sv]
package plp_pkg;

  localparam int IMAGE_DEPTH_DEF = 8192;

  localparam logic [1:0] MODE_SERIAL     = 2'd0;
  localparam logic [1:0] MODE_PRINT_DONE = 2'd1;
  localparam logic [1:0] MODE_READ       = 2'd2;

  localparam logic [7:0] PREAMBLE_A  = 8'h88;
  localparam logic [7:0] PREAMBLE_B  = 8'h33;
  localparam logic [7:0] CMD_INIT    = 8'h01;
  localparam logic [7:0] CMD_PRINT   = 8'h02;
  localparam logic [7:0] CMD_FILL    = 8'h04;
  localparam logic [7:0] ALIVE_REPLY = 8'h81;

  localparam int FLAG_SUM_ERR  = 0;
  localparam int FLAG_PRINTING = 1;
  localparam int FLAG_FULL     = 2;
  localparam int FLAG_UNPROC   = 3;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_CMD    = 9'b000000010,
    PH_COMP   = 9'b000000100,
    PH_LEN_LO = 9'b000001000,
    PH_LEN_HI = 9'b000010000,
    PH_DATA   = 9'b000100000,
    PH_SUM_HI = 9'b001000000,
    PH_ALIVE  = 9'b010000000,
    PH_STATUS = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  serial_in;
    logic [12:0] read_index;
  } req_t;

  typedef struct packed {
    logic [7:0]  response;
    logic        start_print;
    logic [3:0]  top_margin;
    logic [3:0]  bottom_margin;
    logic [7:0]  palette_out;
    logic [7:0]  exposure_out;
    logic [13:0] image_count;
    logic [7:0]  image_data;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  response;
    logic        start_print;
    logic [3:0]  top_margin;
    logic [3:0]  bottom_margin;
    logic [7:0]  palette_out;
    logic [7:0]  exposure_out;
    logic [13:0] image_count;
  } frame_res_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } store_wr_t;

endpackage

[hdl/plp_frame.sv]
module plp_frame #(
  parameter int IMAGE_DEPTH = plp_pkg::IMAGE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  plp_pkg::req_t                         req,
  output plp_pkg::frame_res_t                   res,
  output plp_pkg::store_wr_t                    wr,
  output logic [$clog2(IMAGE_DEPTH)-1:0]        wr_addr,
  output logic [$clog2(IMAGE_DEPTH+1)-1:0]      fill
);
  import plp_pkg::*;

  localparam int FILL_W = $clog2(IMAGE_DEPTH + 1);
  localparam int ADDR_W = $clog2(IMAGE_DEPTH);

  phase_t             phase, phase_next;
  logic               magic, magic_next;
  logic [7:0]         cmd, cmd_next;
  logic [15:0]        plen, plen_next;
  logic [15:0]        pcnt, pcnt_next;
  logic [15:0]        csum, csum_next;
  logic [15:0]        rsum, rsum_next;
  logic [3:0]         flags, flags_next;
  logic [3:0]         top_w, top_w_next;
  logic [3:0]         bot_w, bot_w_next;
  logic [7:0]         pal, pal_next;
  logic [7:0]         expo, expo_next;
  logic [FILL_W-1:0]  fill_next;
  logic [7:0]         resp;
  logic               pulse;
  logic [7:0]         b;

  assign b       = req.serial_in;
  assign wr_addr = ADDR_W'(fill);

  always_comb begin
    phase_next = phase;
    magic_next = magic;
    cmd_next   = cmd;
    plen_next  = plen;
    pcnt_next  = pcnt;
    csum_next  = csum;
    rsum_next  = rsum;
    flags_next = flags;
    top_w_next = top_w;
    bot_w_next = bot_w;
    pal_next   = pal;
    expo_next  = expo;
    fill_next  = fill;
    resp       = 8'd0;
    pulse      = 1'b0;
    wr.en      = 1'b0;
    wr.data    = b;
    if (accept) begin
      case (req.mode)
        MODE_SERIAL: begin
          case (phase)
            PH_IDLE: begin
              if (b == PREAMBLE_A) begin
                magic_next = 1'b1;
              end else begin
                if (b == PREAMBLE_B && magic) begin
                  phase_next = PH_CMD;
                end
                magic_next = 1'b0;
              end
            end
            PH_CMD: begin
              cmd_next   = b;
              csum_next  = csum + {8'd0, b};
              phase_next = PH_COMP;
            end
            PH_COMP: begin
              csum_next  = csum + {8'd0, b};
              phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              plen_next  = {8'd0, b};
              csum_next  = csum + {8'd0, b};
              phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              plen_next  = {b, plen[7:0]};
              csum_next  = csum + {8'd0, b};
              phase_next = PH_DATA;
            end
            PH_DATA: begin
              if (pcnt < plen) begin
                if (cmd == CMD_FILL) begin
                  if (fill < FILL_W'(IMAGE_DEPTH)) begin
                    wr.en     = 1'b1;
                    fill_next = fill + FILL_W'(1);
                  end else begin
                    flags_next[FLAG_FULL] = 1'b1;
                  end
                end else if (cmd == CMD_PRINT) begin
                  if (pcnt == 16'd1) begin
                    top_w_next = b[7:4];
                    bot_w_next = b[3:0];
                  end else if (pcnt == 16'd2) begin
                    pal_next = b;
                  end else if (pcnt == 16'd3) begin
                    expo_next = b;
                  end
                end
                pcnt_next               = pcnt + 16'd1;
                csum_next               = csum + {8'd0, b};
                flags_next[FLAG_UNPROC] = 1'b1;
              end else begin
                rsum_next  = {8'd0, b};
                phase_next = PH_SUM_HI;
              end
            end
            PH_SUM_HI: begin
              rsum_next  = {b, rsum[7:0]};
              phase_next = PH_ALIVE;
            end
            PH_ALIVE: begin
              resp       = ALIVE_REPLY;
              phase_next = PH_STATUS;
            end
            PH_STATUS: begin
              magic_next = 1'b0;
              flags_next = flags;
              if (rsum != csum) begin
                flags_next[FLAG_SUM_ERR] = 1'b1;
              end
              resp = {4'd0, flags_next};
              if (!flags_next[FLAG_PRINTING]) begin
                if (cmd == CMD_INIT) begin
                  flags_next = 4'd0;
                  top_w_next = 4'd0;
                  bot_w_next = 4'd0;
                  pal_next   = 8'd0;
                  expo_next  = 8'd0;
                  fill_next  = '0;
                end else if (cmd == CMD_PRINT) begin
                  flags_next[FLAG_PRINTING] = 1'b1;
                  pulse                     = 1'b1;
                end
              end
              phase_next = PH_IDLE;
              cmd_next   = 8'd0;
              plen_next  = 16'd0;
              pcnt_next  = 16'd0;
              csum_next  = 16'd0;
              rsum_next  = 16'd0;
            end
            default: begin
              phase_next = PH_IDLE;
              magic_next = 1'b0;
              cmd_next   = 8'd0;
              plen_next  = 16'd0;
              pcnt_next  = 16'd0;
              csum_next  = 16'd0;
              rsum_next  = 16'd0;
            end
          endcase
        end
        MODE_PRINT_DONE: begin
          flags_next[FLAG_PRINTING] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.response      = resp;
    res.start_print   = pulse;
    res.top_margin    = top_w_next;
    res.bottom_margin = bot_w_next;
    res.palette_out   = pal_next;
    res.exposure_out  = expo_next;
    res.image_count   = 14'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      magic <= 1'b0;
      cmd   <= 8'd0;
      plen  <= 16'd0;
      pcnt  <= 16'd0;
      csum  <= 16'd0;
      rsum  <= 16'd0;
      flags <= 4'd0;
      top_w <= 4'd0;
      bot_w <= 4'd0;
      pal   <= 8'd0;
      expo  <= 8'd0;
      fill  <= '0;
    end else begin
      phase <= phase_next;
      magic <= magic_next;
      cmd   <= cmd_next;
      plen  <= plen_next;
      pcnt  <= pcnt_next;
      csum  <= csum_next;
      rsum  <= rsum_next;
      flags <= flags_next;
      top_w <= top_w_next;
      bot_w <= bot_w_next;
      pal   <= pal_next;
      expo  <= expo_next;
      fill  <= fill_next;
    end
  end

endmodule

[hdl/printer_link_packet_parser.sv]
// Printer-side packet parser for a handheld console link. It takes one beat per clock when
// not stalled and returns one result beat for each in the cycle after acceptance, held in
// an output register until taken. The request side stalls only while that register holds
// a result that is itself stalled. Image bytes live in a single memory of IMAGE_DEPTH
// bytes with one write and one registered read per cycle; a fill byte is written in the
// cycle it is accepted, so a later read always sees it. Entries beyond the fill count read
// as zero, so the store needs no clearing after reset.
module printer_link_packet_parser #(
  parameter int IMAGE_DEPTH = plp_pkg::IMAGE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  plp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output plp_pkg::rsp_t rsp
);
  import plp_pkg::*;

  localparam int FILL_W = $clog2(IMAGE_DEPTH + 1);
  localparam int ADDR_W = $clog2(IMAGE_DEPTH);
  localparam int CMP_W  = (FILL_W > 13) ? FILL_W : 13;

  logic                accept;
  frame_res_t          res;
  frame_res_t          res_q;
  store_wr_t           wr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [FILL_W-1:0]   fill;
  logic                rd_hit;
  logic                rd_hit_q;
  logic [7:0]          rdata;
  logic [7:0]          mem [IMAGE_DEPTH];

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  plp_frame #(
    .IMAGE_DEPTH(IMAGE_DEPTH)
  ) u_frame (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .res    (res),
    .wr     (wr),
    .wr_addr(wr_addr),
    .fill   (fill)
  );

  assign rd_hit = (req.mode == MODE_READ)
               && (CMP_W'(req.read_index) < CMP_W'(fill))
               && (CMP_W'(req.read_index) < CMP_W'(IMAGE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (accept && rd_hit) begin
      rdata <= mem[ADDR_W'(req.read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q    <= res;
      rd_hit_q <= rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    rsp.response      = res_q.response;
    rsp.start_print   = res_q.start_print;
    rsp.top_margin    = res_q.top_margin;
    rsp.bottom_margin = res_q.bottom_margin;
    rsp.palette_out   = res_q.palette_out;
    rsp.exposure_out  = res_q.exposure_out;
    rsp.image_count   = res_q.image_count;
    rsp.image_data    = rd_hit_q ? rdata : 8'd0;
  end

endmodule

[hdl/plp_checker.sv]
module plp_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input plp_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input plp_pkg::rsp_t rsp
);
  import plp_pkg::*;

  // A start print only executes when the reported flags show no print running.
  a_start_not_printing: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.start_print |-> !rsp.response[FLAG_PRINTING])
    else $error("start print reported while printing");

  // Apart from the alive reply, a response is either zero or the four status flags.
  a_resp_upper_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.response != ALIVE_REPLY |-> rsp.response[7:4] == 4'd0)
    else $error("response upper bits set");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid straight after reset");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("accepted beat gave no result");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

bind printer_link_packet_parser plp_checker u_plp_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import plp_pkg::*;

  localparam int STORE_DEPTH = IMAGE_DEPTH_DEF;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [7:0] CMD_READ_STATUS = 8'h0F;

  typedef enum logic [2:0] {
    ST_CMD, ST_COMP, ST_LEN_LO, ST_LEN_HI, ST_DATA, ST_SUM_HI, ST_ALIVE, ST_STATUS
  } link_stage_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t link_beats_pending [$];
  rsp_t printer_replies_due [$];
  int unsigned beats_queued = 0;
  int unsigned error_count = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_hold = 0;
  int unsigned recv_calm = 0;

  logic        link_open = 1'b0;
  logic        sync_armed = 1'b0;
  link_stage_t pkt_stage = ST_CMD;
  logic [7:0]  pkt_cmd = '0;
  logic [15:0] pkt_len = '0;
  logic [15:0] pkt_seen = '0;
  logic [15:0] sum_calc = '0;
  logic [15:0] sum_given = '0;
  logic [7:0]  flags = '0;
  logic [3:0]  top_w = '0;
  logic [3:0]  bot_w = '0;
  logic [7:0]  pal = '0;
  logic [7:0]  expo = '0;
  logic [13:0] fill_level = '0;
  logic [7:0]  img [STORE_DEPTH];

  printer_link_packet_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  function automatic rsp_t printer_next(req_t r);
    rsp_t       o;
    logic [7:0] b;
    o = '0;
    b = r.serial_in;
    if (r.mode == MODE_SERIAL) begin
      if (!link_open) begin
        if (b == PREAMBLE_A) begin
          sync_armed = 1'b1;
        end else begin
          if (b == PREAMBLE_B && sync_armed) link_open = 1'b1;
          sync_armed = 1'b0;
        end
      end else begin
        case (pkt_stage)
          ST_CMD: begin
            pkt_cmd = b;
            sum_calc = sum_calc + b;
            pkt_stage = ST_COMP;
          end
          ST_COMP: begin
            sum_calc = sum_calc + b;
            pkt_stage = ST_LEN_LO;
          end
          ST_LEN_LO: begin
            pkt_len = {8'h00, b};
            sum_calc = sum_calc + b;
            pkt_stage = ST_LEN_HI;
          end
          ST_LEN_HI: begin
            pkt_len[15:8] = b;
            sum_calc = sum_calc + b;
            pkt_stage = ST_DATA;
          end
          ST_DATA: begin
            if (pkt_seen < pkt_len) begin
              if (pkt_cmd == CMD_FILL) begin
                if (fill_level < STORE_DEPTH) begin
                  img[fill_level[12:0]] = b;
                  fill_level = fill_level + 1'b1;
                end else begin
                  flags[FLAG_FULL] = 1'b1;
                end
              end else if (pkt_cmd == CMD_PRINT) begin
                case (pkt_seen)
                  16'd1: {top_w, bot_w} = b;
                  16'd2: pal = b;
                  16'd3: expo = b;
                  default: ;
                endcase
              end
              pkt_seen = pkt_seen + 1'b1;
              sum_calc = sum_calc + b;
              flags[FLAG_UNPROC] = 1'b1;
            end else begin
              sum_given = {8'h00, b};
              pkt_stage = ST_SUM_HI;
            end
          end
          ST_SUM_HI: begin
            sum_given[15:8] = b;
            pkt_stage = ST_ALIVE;
          end
          ST_ALIVE: begin
            o.response = ALIVE_REPLY;
            pkt_stage = ST_STATUS;
          end
          default: begin
            sync_armed = 1'b0;
            link_open = 1'b0;
            if (sum_given != sum_calc) flags[FLAG_SUM_ERR] = 1'b1;
            o.response = flags;
            if (!flags[FLAG_PRINTING]) begin
              if (pkt_cmd == CMD_INIT) begin
                flags = '0;
                top_w = '0;
                bot_w = '0;
                pal = '0;
                expo = '0;
                fill_level = '0;
              end else if (pkt_cmd == CMD_PRINT) begin
                flags[FLAG_PRINTING] = 1'b1;
                o.start_print = 1'b1;
              end
            end
            pkt_stage = ST_CMD;
            pkt_cmd = '0;
            pkt_len = '0;
            pkt_seen = '0;
            sum_calc = '0;
            sum_given = '0;
          end
        endcase
      end
    end else if (r.mode == MODE_PRINT_DONE) begin
      flags[FLAG_PRINTING] = 1'b0;
    end else if (r.mode == MODE_READ) begin
      if (r.read_index < fill_level) o.image_data = img[r.read_index];
    end
    o.top_margin = top_w;
    o.bottom_margin = bot_w;
    o.palette_out = pal;
    o.exposure_out = expo;
    o.image_count = fill_level;
    return o;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 4);
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  task automatic match_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s mismatch: expected %0h, got %0h", what, want, got));
    end
  endtask

  task automatic queue_beat(logic [1:0] mode, logic [7:0] b, logic [12:0] idx);
    req_t item;
    item.mode = mode;
    item.serial_in = b;
    item.read_index = idx;
    link_beats_pending.push_back(item);
    beats_queued++;
  endtask

  task automatic queue_byte(logic [7:0] b);
    queue_beat(MODE_SERIAL, b, 13'($urandom));
  endtask

  task automatic queue_side_beat();
    case ($urandom_range(0, 3))
      0: queue_beat(MODE_PRINT_DONE, 8'($urandom), 13'($urandom));
      1: queue_beat(MODE_SPARE, 8'($urandom), 13'($urandom));
      default: begin
        queue_beat(MODE_READ, 8'($urandom),
                   $urandom_range(0, 1) ? 13'($urandom_range(0, 63)) : 13'($urandom));
      end
    endcase
  endtask

  // A cut packet has its tail from a random point on replaced by zeros, so the
  // frame still closes on its status beat.
  task automatic queue_packet(logic [7:0] cmd, int unsigned len, bit bad_sum, bit cut);
    logic [7:0]  body [$];
    logic [15:0] sum;
    int unsigned stop;
    sum = '0;
    queue_byte(PREAMBLE_A);
    queue_byte(PREAMBLE_B);
    body.push_back(cmd);
    body.push_back(8'($urandom));
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    for (int i = 0; i < len; i++) body.push_back(8'($urandom));
    foreach (body[i]) sum = sum + body[i];
    if (bad_sum) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    body.push_back(sum[7:0]);
    body.push_back(sum[15:8]);
    body.push_back(8'($urandom));
    body.push_back(8'($urandom));
    stop = cut ? $urandom_range(4, body.size() - 1) : body.size();
    foreach (body[i]) begin
      queue_byte(i < stop ? body[i] : 8'h00);
      if ($urandom_range(0, 11) == 0) queue_side_beat();
    end
  endtask

  task automatic queue_noise();
    logic [7:0] b;
    if ($urandom_range(0, 1)) queue_byte(PREAMBLE_A);
    repeat ($urandom_range(1, 6)) begin
      b = 8'($urandom);
      if (b == PREAMBLE_B) b = 8'h00;
      queue_byte(b);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_valid && !req_stall) printer_replies_due.push_back(printer_next(req));
      if (!req_valid || !req_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (link_beats_pending.size() != 0) begin
          req <= link_beats_pending.pop_front();
          req_valid <= 1'b1;
          send_gap <= draw_wait(send_calm);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (printer_replies_due.size() == 0) begin
          flag_error($sformatf("result beat with nothing expected: %h", rsp));
        end else begin
          rsp_t want;
          want = printer_replies_due.pop_front();
          match_field("response", rsp.response, want.response);
          match_field("start_print", rsp.start_print, want.start_print);
          match_field("top_margin", rsp.top_margin, want.top_margin);
          match_field("bottom_margin", rsp.bottom_margin, want.bottom_margin);
          match_field("palette_out", rsp.palette_out, want.palette_out);
          match_field("exposure_out", rsp.exposure_out, want.exposure_out);
          match_field("image_count", rsp.image_count, want.image_count);
          match_field("image_data", rsp.image_data, want.image_data);
        end
        recv_hold = draw_wait(recv_calm);
      end else if (recv_hold != 0) begin
        recv_hold--;
      end
      rsp_stall <= (recv_hold != 0);
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    queue_beat(MODE_SPARE, 8'hFF, 13'h1FFF);
    queue_beat(MODE_PRINT_DONE, 8'h00, 13'h0000);
    queue_beat(MODE_READ, 8'h00, 13'h0000);
    queue_beat(MODE_READ, 8'hFF, 13'h1FFF);
    queue_byte(PREAMBLE_A);
    queue_byte(8'h00);
    queue_byte(PREAMBLE_B);
    queue_byte(PREAMBLE_A);
    queue_byte(PREAMBLE_A);
    queue_byte(PREAMBLE_B);
    queue_byte(CMD_FILL);
    queue_byte(8'h00);
    queue_byte(8'h02);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h05);
    queue_byte(8'h01);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_beat(MODE_READ, 8'h00, 13'h0000);
    queue_beat(MODE_READ, 8'h00, 13'h0001);

    while (beats_queued < 1020) begin
      case ($urandom_range(0, 11))
        0, 1, 2: queue_packet(CMD_FILL, $urandom_range(0, 12),
                              $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
        3, 4: queue_packet(CMD_PRINT, $urandom_range(0, 2) == 0 ? $urandom_range(0, 6) : 4,
                           $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
        5: queue_packet(CMD_INIT, $urandom_range(0, 3),
                        $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
        6: queue_packet(CMD_READ_STATUS, $urandom_range(0, 2),
                        $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
        7: queue_packet(8'($urandom), $urandom_range(0, 4),
                        $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0);
        8, 9: queue_noise();
        default: repeat ($urandom_range(1, 3)) queue_side_beat();
      endcase
    end

    // Wait until every queued beat is sent and the block has returned every result.
    do @(negedge clk);
    while (link_beats_pending.size() != 0 || req_valid || printer_replies_due.size() != 0);

    queue_packet(CMD_FILL, 3, 1'b0, 1'b0);
    queue_beat(MODE_READ, 8'h00, 13'h1FFF);
    repeat (40) queue_side_beat();
    queue_beat(MODE_PRINT_DONE, 8'h00, 13'h0000);
    queue_packet(CMD_INIT, 0, 1'b0, 1'b0);
    queue_beat(MODE_READ, 8'h00, 13'h0005);
    queue_packet(CMD_PRINT, 4, 1'b0, 1'b0);
    queue_beat(MODE_PRINT_DONE, 8'h00, 13'h0000);
    queue_packet(CMD_PRINT, 4, 1'b0, 1'b0);

    do @(negedge clk);
    while (link_beats_pending.size() != 0 || req_valid || printer_replies_due.size() != 0);
    repeat (8) @(negedge clk);

    if (error_count == 0) begin
      $display("printer_link_packet_parser regression: pass");
    end else begin
      $display("printer_link_packet_parser regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("printer_link_packet_parser regression: fail");
    $finish;
  end

endmodule
